FILE: hw/rtl/held_key_slot_table_unit_assert.svh
`ifndef HELD_KEY_SLOT_TABLE_UNIT_ASSERT_SVH
`define HELD_KEY_SLOT_TABLE_UNIT_ASSERT_SVH

// Checked only outside reset.
`define HKST_ASSERT_RUN(name, clk_sig, rstn_sig, prop, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// Checked on every edge, reset included.
`define HKST_ASSERT_ALL(name, clk_sig, prop, msg) \
    name: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

FILE: hw/rtl/hkst_pkg.sv
package hkst_pkg;

    localparam int unsigned KEY_W     = 8;
    localparam int unsigned OUT_SLOTS = 6;
    localparam int unsigned OUT_W     = OUT_SLOTS * KEY_W;
    localparam int unsigned SLOTS_DEF = 6;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic action;
        key_t key_code;
    } slot_req_t;

endpackage

FILE: hw/rtl/hkst_channels.sv
interface hkst_cmd_if;
    import hkst_pkg::*;

    logic valid;
    logic ready;
    logic action;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output action, output key_code, input ready);
    modport sink (input valid, input action, input key_code, output ready);
endinterface

interface hkst_rsp_if;
    import hkst_pkg::*;

    logic valid;
    logic ready;
    logic ok;
    logic [OUT_W-1:0] slot_contents;

    modport source (output valid, output ok, output slot_contents, input ready);
    modport sink (input valid, input ok, input slot_contents, output ready);
endinterface

FILE: hw/rtl/hkst_slot_logic.sv
module hkst_slot_logic #(
    parameter int unsigned SLOTS = hkst_pkg::SLOTS_DEF
) (
    input  hkst_pkg::slot_req_t                   req,
    input  logic [SLOTS-1:0][hkst_pkg::KEY_W-1:0] slots,
    output logic                                  ok,
    output logic [SLOTS-1:0][hkst_pkg::KEY_W-1:0] slots_next
);
    import hkst_pkg::*;

    logic [SLOTS-1:0] match;
    logic [SLOTS-1:0] empty;
    logic [SLOTS-1:0] first_empty;
    logic [SLOTS-1:0] after_hit;
    logic             code_nz;
    logic             present;
    logic             has_empty;

    assign code_nz   = (req.key_code != '0);
    assign present   = |match;
    assign has_empty = |empty;

    // Slots stay packed and codes unique, so the first empty slot is the one
    // whose lower neighbor is occupied, and at most one slot can match.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match[i] = (slots[i] == req.key_code);
            empty[i] = (slots[i] == '0);
            if (i == 0)
            begin
                first_empty[i] = empty[i];
                after_hit[i]   = match[i];
            end
            else
            begin
                first_empty[i] = empty[i] && !empty[i-1];
                after_hit[i]   = match[i] || after_hit[i-1];
            end
        end
    end

    always_comb
    begin
        slots_next = slots;
        ok         = 1'b0;
        if (code_nz)
        begin
            if (req.action == ACT_ADD)
            begin
                ok = present || has_empty;
                if (!present)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (first_empty[i])
                        begin
                            slots_next[i] = req.key_code;
                        end
                    end
                end
            end
            else
            begin
                ok = present;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (after_hit[i])
                    begin
                        slots_next[i] = (i + 1 < SLOTS) ? slots[(i + 1) % SLOTS] : '0;
                    end
                end
            end
        end
    end

endmodule

FILE: hw/rtl/held_key_slot_table_unit.sv
// Held key table: add/remove key events against a packed row of key slots.
// Response: rsp valid follows the cmd transfer through the input reg, then the result reg.
// Throughput: one event per cycle unless rsp back-pressure stalls; the slot update and
// compare are combinational between the input register and the result register.
// Reset: all slots cleared to empty, both pipeline stages emptied.
`include "held_key_slot_table_unit_assert.svh"

module held_key_slot_table_unit #(
    parameter int unsigned SLOTS = hkst_pkg::SLOTS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    hkst_cmd_if.sink  cmd,
    hkst_rsp_if.source rsp
);
    import hkst_pkg::*;

    logic                        cmd_valid_reg;
    slot_req_t                   cmd_req_reg;
    logic                        rsp_valid_reg;
    logic                        rsp_ok_reg;
    logic [OUT_W-1:0]            rsp_slots_reg;
    logic [SLOTS-1:0][KEY_W-1:0] slots_reg;
    logic [SLOTS-1:0][KEY_W-1:0] slots_next;
    logic [OUT_W-1:0]            packed_next;
    logic                        ok_next;
    logic                        advance;
    logic                        fire;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign fire      = cmd_valid_reg && advance;
    assign cmd.ready = !cmd_valid_reg || advance;

    hkst_slot_logic #(
        .SLOTS (SLOTS)
    ) u_slot_logic (
        .req        (cmd_req_reg),
        .slots      (slots_reg),
        .ok         (ok_next),
        .slots_next (slots_next)
    );

    // Only the first OUT_SLOTS slots are reported.
    always_comb
    begin
        packed_next = '0;
        for (int k = 0; k < OUT_SLOTS; k++)
        begin
            if (k < SLOTS)
            begin
                packed_next[k*KEY_W +: KEY_W] = slots_next[k % SLOTS];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            slots_reg     <= '0;
        end
        else
        begin
            if (cmd.ready)
            begin
                cmd_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= cmd_valid_reg;
            end
            if (fire)
            begin
                slots_reg <= slots_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_req_reg.action   <= cmd.action;
            cmd_req_reg.key_code <= cmd.key_code;
        end
        if (fire)
        begin
            rsp_ok_reg    <= ok_next;
            rsp_slots_reg <= packed_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.ok            = rsp_ok_reg;
    assign rsp.slot_contents = rsp_slots_reg;

    `HKST_ASSERT_ALL(a_packed_front, clk, (slots_reg[0] == '0) |-> (slots_reg == '0), "empty slot 0 with occupied slots")
    `HKST_ASSERT_RUN(a_stall_holds_slots, clk, rst_n, (rsp.valid && !rsp.ready) |=> $stable(slots_reg), "slots changed while result stalled")
    `HKST_ASSERT_RUN(a_zero_code_fails, clk, rst_n, (fire && cmd_req_reg.key_code == '0) |=> !rsp_ok_reg, "zero key code reported ok")
    `HKST_ASSERT_RUN(a_held_item_stays, clk, rst_n, (cmd_valid_reg && !advance) |=> cmd_valid_reg, "pending event dropped")

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hkst_pkg::*;

    localparam int unsigned NUM_KEYS   = SLOTS_DEF;
    localparam int unsigned RAND_ITEMS = 800;

    typedef struct {
        logic             ok;
        logic [OUT_W-1:0] slot_contents;
    } key_report_t;

    logic clk = 1'b0;
    logic rst_n;

    hkst_cmd_if cmd_ch ();
    hkst_rsp_if rsp_ch ();

    held_key_slot_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    slot_req_t   pending_events[$];
    key_report_t expected_reports[$];
    key_t        held_keys[NUM_KEYS];
    int unsigned fail_count;
    int unsigned cycle_count;
    logic        no_idle;

    // No idling on either side during this stretch.
    assign no_idle = (cycle_count >= 250) && (cycle_count < 500);

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Applies one key event to the shadow table and returns the report it yields.
    function automatic key_report_t apply_key_event(input logic act, input key_t code);
        key_report_t rep;
        logic        hit;
        rep.ok = 1'b0;
        rep.slot_contents = '0;
        hit = 1'b0;
        if (code != '0) begin
            if (act == ACT_ADD) begin
                for (int i = 0; i < NUM_KEYS && !hit; i++) begin
                    if (held_keys[i] == code) begin
                        hit = 1'b1;
                    end else if (held_keys[i] == '0) begin
                        held_keys[i] = code;
                        hit = 1'b1;
                    end
                end
            end else begin
                for (int i = 0; i < NUM_KEYS; i++) begin
                    if (held_keys[i] == code) begin
                        for (int j = i; j + 1 < NUM_KEYS; j++)
                            held_keys[j] = held_keys[j + 1];
                        held_keys[NUM_KEYS - 1] = '0;
                        hit = 1'b1;
                    end
                end
            end
        end
        rep.ok = hit;
        for (int i = 0; i < NUM_KEYS && i < OUT_SLOTS; i++)
            rep.slot_contents[i*KEY_W +: KEY_W] = held_keys[i];
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_count <= 0;
        else
            cycle_count <= cycle_count + 1;
    end

    // Event driver: predicts on each accepted transfer, then loads the next event.
    always @(posedge clk or negedge rst_n)
    begin : drive_events
        slot_req_t ev;
        if (!rst_n) begin
            cmd_ch.valid    <= 1'b0;
            cmd_ch.action   <= ACT_ADD;
            cmd_ch.key_code <= '0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready)
                expected_reports.push_back(apply_key_event(cmd_ch.action, cmd_ch.key_code));
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (pending_events.size() != 0 && (no_idle || $urandom_range(99) >= 6)) begin
                    ev = pending_events.pop_front();
                    cmd_ch.valid    <= 1'b1;
                    cmd_ch.action   <= ev.action;
                    cmd_ch.key_code <= ev.key_code;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Report monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin : check_reports
        key_report_t want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 6);
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected report", rsp_ch.slot_contents, '0);
                end else begin
                    want = expected_reports.pop_front();
                    if (rsp_ch.ok !== want.ok)
                        report_mismatch("ok", OUT_W'(rsp_ch.ok), OUT_W'(want.ok));
                    if (rsp_ch.slot_contents !== want.slot_contents)
                        report_mismatch("slot_contents", rsp_ch.slot_contents,
                                        want.slot_contents);
                end
            end
        end
    end

    task automatic queue_event(input logic act, input key_t code);
        slot_req_t ev;
        ev.action   = act;
        ev.key_code = code;
        pending_events.push_back(ev);
    endtask

    initial
    begin
        key_t        key_pool[10];
        int unsigned add_pct;
        int unsigned roll;
        key_t        code;
        logic        act;

        rst_n = 1'b0;
        fail_count = 0;
        foreach (held_keys[i])
            held_keys[i] = '0;

        // Directed: zero code, absent remove, duplicate add, full table,
        // removes from front, back and middle, then drain to empty.
        queue_event(ACT_ADD,    8'h00);
        queue_event(ACT_REMOVE, 8'h00);
        queue_event(ACT_REMOVE, 8'h04);
        queue_event(ACT_ADD,    8'h04);
        queue_event(ACT_ADD,    8'h04);
        queue_event(ACT_ADD,    8'hFF);
        queue_event(ACT_ADD,    8'h80);
        queue_event(ACT_ADD,    8'h01);
        queue_event(ACT_ADD,    8'h7F);
        queue_event(ACT_ADD,    8'h55);
        queue_event(ACT_ADD,    8'hAA);
        queue_event(ACT_ADD,    8'h80);
        queue_event(ACT_ADD,    8'h00);
        queue_event(ACT_REMOVE, 8'h00);
        queue_event(ACT_REMOVE, 8'h04);
        queue_event(ACT_REMOVE, 8'h55);
        queue_event(ACT_REMOVE, 8'h80);
        queue_event(ACT_REMOVE, 8'h99);
        queue_event(ACT_ADD,    8'hAA);
        queue_event(ACT_REMOVE, 8'hFF);
        queue_event(ACT_REMOVE, 8'h01);
        queue_event(ACT_REMOVE, 8'h7F);
        queue_event(ACT_REMOVE, 8'hAA);
        queue_event(ACT_REMOVE, 8'hAA);

        // Random: a small key pool keeps the table filling and emptying;
        // the add/remove mix shifts every 50 events.
        foreach (key_pool[i])
            key_pool[i] = key_t'($urandom_range(1, 255));
        add_pct = 50;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 50 == 0)
                add_pct = 30 + 20 * $urandom_range(3);
            act = ($urandom_range(99) < add_pct) ? ACT_ADD : ACT_REMOVE;
            roll = $urandom_range(99);
            if (roll < 85)
                code = key_pool[$urandom_range(9)];
            else if (roll < 90)
                code = '0;
            else
                code = key_t'($urandom_range(255));
            queue_event(act, code);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_events.size() != 0 || cmd_ch.valid)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_reports.size() != 0)
            report_mismatch("reports missing", OUT_W'(expected_reports.size()), '0);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #200us;
        $display("Some tests failed");
        $finish;
    end

endmodule
